// ----- rtl/complex_fir_filter_top_assert.svh -----
// Assertion macros for the complex FIR filter.
// Included by files that check their own control logic; no other dependencies.
`ifndef COMPLEX_FIR_FILTER_TOP_ASSERT_SVH
`define COMPLEX_FIR_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition c holds in the same cycle as a.
`define CFIR_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("cfir: same-cycle check failed");

// The condition c holds in the cycle after a.
`define CFIR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("cfir: next-cycle check failed");

`else

`define CFIR_ASSERT_IMPLY(label, clk, rst_n, a, c)
`define CFIR_ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

// ----- rtl/cfir_pkg.sv -----
// Shared types and constants of the complex FIR filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cfir_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 16;
    localparam int COEF_IDX_W    = 6;
    localparam int TAP_COUNT_W   = 7;
    localparam int PROD_W        = SAMPLE_W + COEF_W;

    localparam int MAX_TAPS_DEF       = 64;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample_real;
        logic signed [SAMPLE_W-1:0] sample_imag;
        logic                       block_last;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_real;
        logic signed [SAMPLE_W-1:0] out_imag;
        logic                       clipped;
        logic                       out_last;
    } out_word_t;

    // One tap step handed from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic zero;
    } mac_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic                       clip;
    } sat_t;

endpackage

// ----- rtl/cfir_ram.sv -----
// Simple dual-port synchronous RAM with one write and one registered read port.
// Holds the delay line and the tap table; takes its default sizes from cfir_pkg.
`timescale 1ns / 1ps

module cfir_ram
    import cfir_pkg::*;
#(
    parameter int DEPTH = MAX_TAPS_DEF,
    parameter int WIDTH = PROD_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cfir_mac.sv -----
// Shared complex multiply-accumulate unit: product, accumulate and saturate stages.
// Depends on cfir_pkg; fed by the sequencer in the top level and the two RAMs.
`timescale 1ns / 1ps

module cfir_mac
    import cfir_pkg::*;
#(
    parameter int ACC_W          = PROD_W + 8,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mac_beat_t                  beat,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] smp_re,
    input  logic signed [SAMPLE_W-1:0] smp_im,
    output logic                       done,
    output sat_t                       res_re,
    output sat_t                       res_im
);

    localparam logic [ACC_W-1:0] POS_LIM = ACC_W'(32767);
    localparam logic [ACC_W-1:0] NEG_LIM = ACC_W'(32768);

    mac_beat_t                 beat_d1_reg, beat_d2_reg;
    logic signed [PROD_W-1:0]  prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;
    logic                      acc_done_reg;
    logic                      done_reg;
    sat_t                      res_re_reg, res_im_reg;
    logic signed [ACC_W-1:0]   ext_re, ext_im;
    logic signed [PROD_W-1:0]  mul_re, mul_im;

    // Divide by 2^COEF_FRAC_BITS toward zero, then clamp to the 16-bit range.
    function automatic sat_t sat_rail(input logic signed [ACC_W-1:0] sum);
        logic             neg;
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        sat_t             r;
        neg = sum[ACC_W-1];
        mag = neg ? (~sum + 1'b1) : sum;
        q   = mag >> COEF_FRAC_BITS;
        if (!neg && (q > POS_LIM)) begin
            r.val  = SAT_MAX;
            r.clip = 1'b1;
        end else if (neg && (q > NEG_LIM)) begin
            r.val  = SAT_MIN;
            r.clip = 1'b1;
        end else begin
            r.val  = neg ? (~q[SAMPLE_W-1:0] + 1'b1) : q[SAMPLE_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Both operands are sign-extended to the full product width before they multiply.
    assign mul_re = PROD_W'(coef) * PROD_W'(smp_re);
    assign mul_im = PROD_W'(coef) * PROD_W'(smp_im);

    assign ext_re = {{(ACC_W-PROD_W){prod_re_reg[PROD_W-1]}}, prod_re_reg};
    assign ext_im = {{(ACC_W-PROD_W){prod_im_reg[PROD_W-1]}}, prod_im_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_d1_reg  <= '0;
            beat_d2_reg  <= '0;
            acc_done_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            // RAM data arrives in the cycle after the beat that addressed it.
            beat_d1_reg  <= beat;
            beat_d2_reg  <= beat_d1_reg;
            acc_done_reg <= beat_d2_reg.valid && beat_d2_reg.last;
            done_reg     <= acc_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_d1_reg.valid) begin
            // A zero tap count still runs one beat so that the sum comes out as zero.
            prod_re_reg <= beat_d1_reg.zero ? '0 : mul_re;
            prod_im_reg <= beat_d1_reg.zero ? '0 : mul_im;
        end
        if (beat_d2_reg.valid) begin
            acc_re_reg <= beat_d2_reg.first ? ext_re : acc_re_reg + ext_re;
            acc_im_reg <= beat_d2_reg.first ? ext_im : acc_im_reg + ext_im;
        end
        if (acc_done_reg) begin
            res_re_reg <= sat_rail(acc_re_reg);
            res_im_reg <= sat_rail(acc_im_reg);
        end
    end

    assign done   = done_reg;
    assign res_re = res_re_reg;
    assign res_im = res_im_reg;

endmodule

// ----- rtl/complex_fir_filter_top.sv -----
// Top level of the complex FIR filter: sequencer, delay-line and tap RAMs, output register.
// Depends on cfir_pkg, cfir_ram, cfir_mac and complex_fir_filter_top_assert.svh.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid s_ready s_data         | sample or coefficient word
//  result   | m_valid m_ready m_data         | filtered complex word
//  config   | cfg_wr_en cfg_wr_data          | tap count, no read-back
//
// A coefficient word leaves the block in ST_IDLE, ready for the next word. A sample word
// passes through ST_RUN and ST_DRAIN before the next word is taken; the single read port
// of each RAM feeds one tap a cycle into the shared multiply-accumulate unit. After reset
// a clearing pass zeroes both RAMs while s_ready stays low. A result waiting in the output
// register does not block the next word; only a second finished result stalls there.
`timescale 1ns / 1ps

`include "complex_fir_filter_top_assert.svh"

module complex_fir_filter_top
    import cfir_pkg::*;
#(
    parameter int MAX_TAPS       = MAX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [TAP_COUNT_W-1:0] cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]       wp_reg, wp_next;
    logic [IDX_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]       tap_idx_reg, tap_idx_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic                   zero_reg, zero_next;
    logic                   first_reg, first_next;
    logic                   last_reg, last_next;
    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_data_reg, m_data_next;

    logic                   line_we, coef_we, mem_re;
    logic [IDX_W-1:0]       line_waddr, coef_waddr;
    logic [PROD_W-1:0]      line_wdata, line_rdata;
    logic [COEF_W-1:0]      coef_wdata, coef_rdata;
    logic [CNT_W-1:0]       taps;
    logic                   in_acc, out_free, load_out;
    mac_beat_t              beat;
    logic                   mac_done;
    sat_t                   res_re, res_im;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign taps     = (int'(tap_count_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                       : CNT_W'(tap_count_reg);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        wp_next      = wp_reg;
        rd_addr_next = rd_addr_reg;
        tap_idx_next = tap_idx_reg;
        rem_next     = rem_reg;
        zero_next    = zero_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        line_we      = 1'b0;
        coef_we      = 1'b0;
        line_waddr   = wp_reg;
        coef_waddr   = IDX_W'(s_data.coef_index);
        line_wdata   = {s_data.sample_real, s_data.sample_imag};
        coef_wdata   = s_data.coef_value;
        mem_re       = 1'b0;
        beat         = '0;
        load_out     = 1'b0;
        s_ready      = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                line_we      = 1'b1;
                coef_we      = 1'b1;
                line_waddr   = clr_cnt_reg;
                coef_waddr   = clr_cnt_reg;
                line_wdata   = '0;
                coef_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_acc) begin
                    if (s_data.req_type == REQ_COEF) begin
                        coef_we = int'(s_data.coef_index) < MAX_TAPS;
                    end else begin
                        // The newest sample is read back first, in the cycle after it is written.
                        line_we      = 1'b1;
                        rd_addr_next = wp_reg;
                        wp_next      = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
                        tap_idx_next = '0;
                        zero_next    = (taps == '0);
                        rem_next     = (taps == '0) ? '0 : taps - 1'b1;
                        first_next   = 1'b1;
                        last_next    = s_data.block_last;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                mem_re       = 1'b1;
                beat.valid   = 1'b1;
                beat.first   = first_reg;
                beat.last    = (rem_reg == '0);
                beat.zero    = zero_reg;
                first_next   = 1'b0;
                rem_next     = rem_reg - 1'b1;
                tap_idx_next = tap_idx_reg + 1'b1;
                rd_addr_next = (rd_addr_reg == '0) ? LAST_IDX : rd_addr_reg - 1'b1;
                if (rem_reg == '0) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // The unit keeps its result until the next sample starts.
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next         = 1'b1;
            m_data_next.out_real = res_re.val;
            m_data_next.out_imag = res_im.val;
            m_data_next.clipped  = res_re.clip || res_im.clip;
            m_data_next.out_last = last_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            rd_addr_reg   <= '0;
            tap_idx_reg   <= '0;
            rem_reg       <= '0;
            zero_reg      <= 1'b0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            tap_count_reg <= TAP_COUNT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wp_reg        <= wp_next;
            rd_addr_reg   <= rd_addr_next;
            tap_idx_reg   <= tap_idx_next;
            rem_reg       <= rem_next;
            zero_reg      <= zero_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            if (cfg_wr_en) begin
                tap_count_reg <= cfg_wr_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cfir_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (PROD_W),
        .AW    (IDX_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (line_rdata)
    );

    cfir_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (COEF_W),
        .AW    (IDX_W)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .re    (mem_re),
        .raddr (tap_idx_reg),
        .rdata (coef_rdata)
    );

    cfir_mac #(
        .ACC_W          (ACC_W),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (beat),
        .coef    (coef_rdata),
        .smp_re  (line_rdata[PROD_W-1:SAMPLE_W]),
        .smp_im  (line_rdata[SAMPLE_W-1:0]),
        .done    (mac_done),
        .res_re  (res_re),
        .res_im  (res_im)
    );

    // No word is taken while a tap step is being issued to the RAMs.
    `CFIR_ASSERT_IMPLY(a_ready_not_running, aclk, aresetn, s_ready, !beat.valid)
    // A finished sum appears only while the sequencer waits for it.
    `CFIR_ASSERT_IMPLY(a_done_in_drain, aclk, aresetn, mac_done, state_reg == ST_DRAIN)
    // A coefficient word leaves the delay-line write position alone.
    `CFIR_ASSERT_NEXT(a_coef_keeps_wp, aclk, aresetn,
        in_acc && (s_data.req_type == REQ_COEF), $stable(wp_reg))

endmodule
